/* hdl/int8_requantizer_macros.svh */
// Assertion helpers for the requantizer RTL.
`ifndef INT8_REQUANTIZER_MACROS_SVH
`define INT8_REQUANTIZER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RQZ_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("requantizer invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define RQZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("requantizer next-cycle check failed");

`endif

/* hdl/rqz_pkg.sv */
package rqz_pkg;

   localparam int ACC_W   = 32;
   localparam int BIAS_W  = 32;
   localparam int MULT_W  = 31;
   localparam int SHIFT_W = 6;
   localparam int CH_W    = 8;
   localparam int CSR_W   = 9;
   localparam int RES_W   = 8;

   localparam int DEFAULT_CHANNELS = 256;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [CSR_W-1:0] CIU_RESET = 9'd1;

   typedef enum logic {
      ACT_COMPUTE = 1'b0,
      ACT_LOAD    = 1'b1
   } action_type;

   // One channel's parameters as held in the table.
   typedef struct packed {
      logic [BIAS_W-1:0]  bias;
      logic [MULT_W-1:0]  mult;
      logic [SHIFT_W-1:0] shift;
      logic               relu;
   } entry_type;

   // A classified compute item travelling from the front to the back.
   typedef struct packed {
      logic [ACC_W-1:0] acc;
      entry_type        entry;
      logic             err;
   } op_type;

endpackage

/* hdl/rqz_req_if.sv */
interface rqz_req_if
   import rqz_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [ACC_W-1:0]   accumulator;
   logic [CH_W-1:0]    channel;
   logic [BIAS_W-1:0]  bias_in;
   logic [MULT_W-1:0]  multiplier_in;
   logic [SHIFT_W-1:0] shift_in;
   logic               relu_in;

   modport source (
      output valid, action, accumulator, channel, bias_in, multiplier_in, shift_in,
             relu_in,
      input  ready
   );

   modport sink (
      input  valid, action, accumulator, channel, bias_in, multiplier_in, shift_in,
             relu_in,
      output ready
   );
endinterface

/* hdl/rqz_rsp_if.sv */
interface rqz_rsp_if
   import rqz_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] result;
   logic             channel_error;

   modport source (
      output valid, result, channel_error,
      input  ready
   );

   modport sink (
      input  valid, result, channel_error,
      output ready
   );
endinterface

/* hdl/int8_requantizer.sv */
// int8 requantizer: turns 32-bit signed accumulators into saturated int8 values
// using a per-channel table of bias, multiplier, right shift and ReLU flag.
// req_bus carries one transaction per item: action selects a compute or a load;
// loads write the table and give no response. rsp_bus returns one transaction per
// compute item: the int8 result and channel_error for an unavailable channel.
// csr_write_enable/csr_write_data set the number of channels in use (reset 1,
// which makes every compute item use entry 0); write it only while idle.
// The lookup register hands the accepted transaction to the queue, the queue hands it
// to the arithmetic pipeline, and the pipeline carries it through six stages to
// rsp_bus.valid; the 32x31 multiply and the 64-bit rounding add each take a stage.
// Throughput is one item per cycle while the receiver does not stall, set by the
// single-port table read and the fully pipelined back end.
// A stalled receiver freezes the back pipeline; req_bus.ready stays high until the
// four-entry queue and the lookup register are both full. Reset empties the
// pipeline and queue and sets channels in use to 1; the table contents are
// undefined until loaded.
`include "int8_requantizer_macros.svh"

module int8_requantizer
   import rqz_pkg::*;
   #(
      parameter int CHANNELS = DEFAULT_CHANNELS
   ) (
      input  logic             clock,
      input  logic             reset,
      rqz_req_if.sink          req_bus,
      rqz_rsp_if.source        rsp_bus,
      input  logic             csr_write_enable,
      input  logic [CSR_W-1:0] csr_write_data
   );

   localparam int LvlW = $clog2(QUEUE_DEPTH + 1);

   logic [CSR_W-1:0] ciu_ff, ciu_in;
   logic             push_valid;
   logic             push_ready;
   op_type           push_data;
   logic             pop_valid;
   logic             pop_ready;
   op_type           pop_data;
   logic [LvlW-1:0]  q_level;

   assign ciu_in = csr_write_enable ? csr_write_data : ciu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ciu_ff <= CIU_RESET;
      end else begin
         ciu_ff <= ciu_in;
      end
   end

   rqz_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .channels_in_use(ciu_ff),
      .push_valid     (push_valid),
      .push_data      (push_data),
      .push_ready     (push_ready)
   );

   rqz_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_ready(push_ready),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .level     (q_level)
   );

   rqz_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_data (pop_data),
      .pop_ready(pop_ready),
      .rsp_bus  (rsp_bus)
   );

   `RQZ_ASSERT_ALWAYS(a_err_result_zero, clock, reset, !(rsp_bus.valid && rsp_bus.channel_error) || (rsp_bus.result == '0))
   `RQZ_ASSERT_ALWAYS(a_queue_bounded, clock, reset, q_level <= LvlW'(QUEUE_DEPTH))
   `RQZ_ASSERT_NEXT(a_load_no_push, clock, reset, req_bus.valid && req_bus.ready && (req_bus.action == ACT_LOAD), !push_valid)
   `RQZ_ASSERT_NEXT(a_stall_keeps_queue, clock, reset, rsp_bus.valid && !rsp_bus.ready, q_level >= $past(q_level))

endmodule

/* hdl/rqz_front.sv */
module rqz_front
   import rqz_pkg::*;
   #(
      parameter int CHANNELS = DEFAULT_CHANNELS
   ) (
      input  logic             clock,
      input  logic             reset,
      rqz_req_if.sink          req_bus,
      input  logic [CSR_W-1:0] channels_in_use,
      output logic             push_valid,
      output op_type           push_data,
      input  logic             push_ready
   );

   localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ChWideW = IdxW + CH_W;

   entry_type table_mem [CHANNELS];

   logic               accept;
   logic               is_load;
   logic               bcast;
   logic               in_table;
   logic               err_in;
   logic [ChWideW-1:0] ch_wide;
   logic [IdxW-1:0]    rd_idx;
   entry_type          wr_entry;

   logic               valid_ff, valid_in;
   logic [ACC_W-1:0]   acc_ff;
   logic               err_ff;
   entry_type          rd_ff;

   assign req_bus.ready = !valid_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_load       = (req_bus.action == ACT_LOAD);

   assign ch_wide  = {{IdxW{1'b0}}, req_bus.channel};
   assign in_table = (ch_wide < ChWideW'(CHANNELS));
   assign bcast    = (channels_in_use == CSR_W'(1));
   assign err_in   = !bcast && ((channels_in_use == '0) ||
                     ({1'b0, req_bus.channel} >= channels_in_use) || !in_table);
   assign rd_idx   = bcast ? '0 : ch_wide[IdxW-1:0];

   assign wr_entry.bias  = req_bus.bias_in;
   assign wr_entry.mult  = req_bus.multiplier_in;
   assign wr_entry.shift = req_bus.shift_in;
   assign wr_entry.relu  = req_bus.relu_in;

   // The stage frees up whenever its content moves on, so a new item may enter then.
   always_comb begin
      valid_in = valid_ff;
      if (req_bus.ready) begin
         valid_in = accept && !is_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // A load writes in the cycle it is accepted, so a compute item straight after it
   // already reads the new entry.
   always_ff @(posedge clock) begin
      if (accept && is_load && in_table) begin
         table_mem[ch_wide[IdxW-1:0]] <= wr_entry;
      end
      if (accept && !is_load && !err_in) begin
         rd_ff <= table_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_load) begin
         acc_ff <= req_bus.accumulator;
         err_ff <= err_in;
      end
   end

   assign push_valid      = valid_ff;
   assign push_data.acc   = acc_ff;
   assign push_data.entry = rd_ff;
   assign push_data.err   = err_ff;

endmodule

/* hdl/rqz_queue.sv */
module rqz_queue
   import rqz_pkg::*;
   #(
      parameter int DEPTH = QUEUE_DEPTH
   ) (
      input  logic                       clock,
      input  logic                       reset,
      input  logic                       push_valid,
      input  op_type                     push_data,
      output logic                       push_ready,
      output logic                       pop_valid,
      output op_type                     pop_data,
      input  logic                       pop_ready,
      output logic [$clog2(DEPTH+1)-1:0] level
   );

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LvlW = $clog2(DEPTH + 1);

   op_type slot_ff [DEPTH];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LvlW-1:0] level_ff, level_in;
   logic            push;
   logic            pop;

   assign push_ready = (level_ff != LvlW'(DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign level      = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LvlW'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LvlW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/rqz_back.sv */
module rqz_back
   import rqz_pkg::*;
   (
      input  logic     clock,
      input  logic     reset,
      input  logic     pop_valid,
      input  op_type   pop_data,
      output logic     pop_ready,
      rqz_rsp_if.source rsp_bus
   );

   localparam int SumW  = ACC_W + 2;
   localparam int MagW  = ACC_W + 1;
   localparam int ProdW = ACC_W + MULT_W;
   localparam int RndW  = ProdW + 1;

   // Each stage carries the fields that later stages still need.
   typedef struct packed {
      logic [MULT_W-1:0]  mult;
      logic [SHIFT_W-1:0] shift;
      logic               relu;
      logic               err;
   } ctl_type;

   logic en;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   ctl_type            c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;
   logic               n2_ff, n3_ff, n4_ff, n5_ff;
   logic [SumW-1:0]    sum1_ff, sum1_in;
   logic [MagW-1:0]    mag2_ff, mag2_in;
   logic [SumW-1:0]    neg_sum;
   logic [ProdW-1:0]   plo3_ff, plo3_in;
   logic               hi3_ff;
   logic [ProdW-1:0]   prod4_ff, prod4_in;
   logic [RndW-1:0]    half;
   logic [RndW-1:0]    rnd5_ff, rnd5_in;
   logic [RES_W-1:0]   result_ff, result_in;
   logic               cerr_ff;
   logic               is_neg;
   ctl_type            c0;

   // The whole pipeline moves together; the queue in front absorbs the stall.
   assign en        = !v6_ff || rsp_bus.ready;
   assign pop_ready = en;

   assign c0.mult  = pop_data.entry.mult;
   assign c0.shift = pop_data.entry.shift;
   assign c0.relu  = pop_data.entry.relu;
   assign c0.err   = pop_data.err;

   assign sum1_in  = {{2{pop_data.acc[ACC_W-1]}}, pop_data.acc} +
                     {{2{pop_data.entry.bias[BIAS_W-1]}}, pop_data.entry.bias};
   assign neg_sum  = SumW'(0) - sum1_ff;
   assign mag2_in  = sum1_ff[SumW-1] ? neg_sum[MagW-1:0] : sum1_ff[MagW-1:0];

   // The magnitude reaches bit 32 only when it is exactly 2^32, so the low
   // product is then zero and the high term is added on its own.
   assign plo3_in  = ProdW'(mag2_ff[ACC_W-1:0]) * ProdW'(c2_ff.mult);
   assign prod4_in = plo3_ff + (hi3_ff ? {c3_ff.mult, {ACC_W{1'b0}}} : ProdW'(0));

   assign half     = (c4_ff.shift == '0) ? RndW'(0)
                     : (RndW'(1) << (c4_ff.shift - SHIFT_W'(1)));
   assign rnd5_in  = ({1'b0, prod4_ff} + half) >> c4_ff.shift;

   always_comb begin
      is_neg    = n5_ff && (rnd5_ff != '0);
      result_in = '0;
      if (c5_ff.err) begin
         result_in = '0;
      end else if (is_neg && c5_ff.relu) begin
         result_in = '0;
      end else if (is_neg) begin
         result_in = (rnd5_ff > RndW'(128)) ? 8'h80 : (RES_W'(0) - rnd5_ff[RES_W-1:0]);
      end else begin
         result_in = (rnd5_ff > RndW'(127)) ? 8'h7F : rnd5_ff[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= pop_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff     <= c0;
         sum1_ff   <= sum1_in;
         c2_ff     <= c1_ff;
         n2_ff     <= sum1_ff[SumW-1];
         mag2_ff   <= mag2_in;
         c3_ff     <= c2_ff;
         n3_ff     <= n2_ff;
         plo3_ff   <= plo3_in;
         hi3_ff    <= mag2_ff[MagW-1];
         c4_ff     <= c3_ff;
         n4_ff     <= n3_ff;
         prod4_ff  <= prod4_in;
         c5_ff     <= c4_ff;
         n5_ff     <= n4_ff;
         rnd5_ff   <= rnd5_in;
         result_ff <= result_in;
         cerr_ff   <= c5_ff.err;
      end
   end

   assign rsp_bus.valid         = v6_ff;
   assign rsp_bus.result        = result_ff;
   assign rsp_bus.channel_error = cerr_ff;

endmodule
